[sv/assert_macros.svh]
// Assertion helpers, clocked on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every edge out of reset.
`define APC_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the same edge.
`define APC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[sv/apc_pkg.sv]
`timescale 1ns / 1ps
package apc_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEFF_W  = 18;
	localparam int COUNT_W  = 5;
	localparam int SAT_IN_W = 20;

	typedef enum logic [1:0] {
		REG_RUN_ENABLE    = 2'd0,
		REG_INVERT_I      = 2'd1,
		REG_STAGE_COUNT   = 2'd2,
		REG_ALLPASS_COEFF = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic advance;
		logic active;
		logic clear;
	} cell_ctrl_t;

	function automatic logic signed [SAMPLE_W-1:0] sat_sample(
		input logic signed [SAT_IN_W-1:0] v
	);
		logic signed [SAT_IN_W-1:0] hi;
		logic signed [SAT_IN_W-1:0] lo;
		hi = SAT_IN_W'(32767);
		lo = -SAT_IN_W'(32768);
		if (v > hi) begin
			sat_sample = 16'sh7FFF;
		end else if (v < lo) begin
			sat_sample = 16'sh8000;
		end else begin
			sat_sample = v[SAMPLE_W-1:0];
		end
	endfunction

endpackage

[sv/apc_cell.sv]
`timescale 1ns / 1ps
module apc_cell import apc_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cell_ctrl_t                 ctrl,
	input  logic signed [COEFF_W-1:0]  coeff,
	input  logic                       v_in,
	input  logic signed [SAMPLE_W-1:0] x_in,
	input  logic signed [SAMPLE_W-1:0] q_in,
	output logic                       v_out,
	output logic signed [SAMPLE_W-1:0] x_out,
	output logic signed [SAMPLE_W-1:0] q_out
);

	logic signed [SAMPLE_W-1:0] xp_q;
	logic signed [SAMPLE_W-1:0] yp_q;
	logic                       vld_s1;
	logic signed [SAMPLE_W-1:0] x_s1;
	logic signed [SAMPLE_W-1:0] q_s1;

	logic signed [SAMPLE_W:0]               diff;
	logic signed [COEFF_W+SAMPLE_W:0]       prod;
	logic signed [COEFF_W+SAMPLE_W+1:0]     acc;
	logic signed [COEFF_W+SAMPLE_W+1-17:0]  flo;
	logic signed [SAMPLE_W-1:0]             y;

	// y = c*(x - y_prev) + x_prev, Q1.17 * Q1.15, round half up to Q1.15
	assign diff = {x_in[SAMPLE_W-1], x_in} - {yp_q[SAMPLE_W-1], yp_q};
	assign prod = (COEFF_W+SAMPLE_W+1)'(coeff) * (COEFF_W+SAMPLE_W+1)'(diff);
	assign acc  = (COEFF_W+SAMPLE_W+2)'(prod)
		+ ((COEFF_W+SAMPLE_W+2)'(xp_q) <<< 17)
		+ (COEFF_W+SAMPLE_W+2)'(65536);
	assign flo  = acc[COEFF_W+SAMPLE_W+1:17];
	assign y    = sat_sample(SAT_IN_W'(flo));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xp_q   <= '0;
			yp_q   <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (ctrl.clear) begin
				xp_q <= '0;
				yp_q <= '0;
			end else if (ctrl.advance && v_in && ctrl.active) begin
				xp_q <= x_in;
				yp_q <= y;
			end
			if (ctrl.advance) begin
				vld_s1 <= v_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.advance) begin
			x_s1 <= ctrl.active ? y : x_in;
			q_s1 <= q_in;
		end
	end

	assign v_out = vld_s1;
	assign x_out = x_s1;
	assign q_out = q_s1;

endmodule

[sv/allpass_cascade_phase_rotator.sv]
`timescale 1ns / 1ps
// Phase rotator on the I part of a complex stream: a row of first-order allpass cells.
// Input channel: i_in, q_in with in_valid / in_stall; a transfer happens when
// in_valid is high and in_stall low. Output channel: i_out, q_out with
// out_valid / out_stall, same rule. Q is carried through untouched.
// Configuration: cfg_valid / cfg_ready (always ready), cfg_index selects run_enable,
// invert_i, stage_count or allpass_coeff; cfg_data holds the value, LSB aligned.
// Writing run_enable or stage_count clears every cell's history.
// Registers from input transfer to output valid: one input register plus one
// register per cell, independent of stage_count; cells past the active count
// pass the sample along unchanged.
// Throughput: one sample per cycle while the output is not stalled; each cell's
// multiply-add-saturate loop is combinational on its own previous input and output.
// Output stall freezes the whole chain while a result is waiting, and in_stall
// follows; bubbles in flight do not stall the input.
// Reset clears all valid flags and cell history and loads the register defaults
// (bypass, no inversion, one stage, coefficient zero).
`include "assert_macros.svh"
module allpass_cascade_phase_rotator import apc_pkg::*; #(
	parameter int MAX_STAGES = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] i_in,
	input  logic signed [SAMPLE_W-1:0] q_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [SAMPLE_W-1:0] i_out,
	output logic signed [SAMPLE_W-1:0] q_out,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [COEFF_W-1:0]         cfg_data
);

	logic                      run_q;
	logic                      invert_q;
	logic [COUNT_W-1:0]        stage_count_q;
	logic signed [COEFF_W-1:0] coeff_q;

	logic clear;
	logic advance;

	logic                       vld_s0;
	logic signed [SAMPLE_W-1:0] x_s0;
	logic signed [SAMPLE_W-1:0] q_s0;
	logic signed [SAMPLE_W:0]   neg_i;

	logic                       v_chain [0:MAX_STAGES];
	logic signed [SAMPLE_W-1:0] x_chain [0:MAX_STAGES];
	logic signed [SAMPLE_W-1:0] q_chain [0:MAX_STAGES];

	assign cfg_ready = 1'b1;

	always_comb begin
		clear = 1'b0;
		if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_RUN_ENABLE:  clear = 1'b1;
				REG_STAGE_COUNT: clear = 1'b1;
				default:         clear = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q         <= 1'b0;
			invert_q      <= 1'b0;
			stage_count_q <= COUNT_W'(1);
			coeff_q       <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_RUN_ENABLE:    run_q <= cfg_data[0];
				REG_INVERT_I:      invert_q <= cfg_data[0];
				REG_STAGE_COUNT:   stage_count_q <= cfg_data[COUNT_W-1:0];
				REG_ALLPASS_COEFF: coeff_q <= cfg_data;
				default:           run_q <= run_q;
			endcase
		end
	end

	assign advance  = !out_valid || !out_stall;
	assign in_stall = !advance;

	assign neg_i = -{i_in[SAMPLE_W-1], i_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (advance) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			x_s0 <= invert_q ? sat_sample(SAT_IN_W'(neg_i)) : i_in;
			q_s0 <= q_in;
		end
	end

	assign v_chain[0] = vld_s0;
	assign x_chain[0] = x_s0;
	assign q_chain[0] = q_s0;

	for (genvar k = 0; k < MAX_STAGES; k++) begin : g_cell
		localparam logic [31:0] CellIdx = 32'(k);
		localparam bit          IsFirst = (k == 0);
		cell_ctrl_t ctrl;

		// stage count of zero acts as one; above MAX_STAGES every cell is active
		assign ctrl.advance = advance;
		assign ctrl.clear   = clear;
		assign ctrl.active  = run_q && (IsFirst || (CellIdx < 32'(stage_count_q)));

		apc_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.coeff  (coeff_q),
			.v_in   (v_chain[k]),
			.x_in   (x_chain[k]),
			.q_in   (q_chain[k]),
			.v_out  (v_chain[k+1]),
			.x_out  (x_chain[k+1]),
			.q_out  (q_chain[k+1])
		);
	end

	assign out_valid = v_chain[MAX_STAGES];
	assign i_out     = x_chain[MAX_STAGES];
	assign q_out     = q_chain[MAX_STAGES];

	`APC_ASSERT_IMPL(a_stall_back, out_valid && out_stall, in_stall, "input not stalled behind held output")
	`APC_ASSERT(a_no_drop, !$fell(out_valid) || $past(!out_stall), "output valid dropped without a transfer")
	`APC_ASSERT_IMPL(a_free_run, !out_valid, !in_stall, "input stalled with empty output")

endmodule

[dv/allpass_cascade_phase_rotator_tb.sv]
`timescale 1ns / 1ps
module allpass_cascade_phase_rotator_tb import apc_pkg::*;;

	localparam int CASCADE_DEPTH  = 16;
	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 10;
	localparam int SETTLE_CYCLES  = CASCADE_DEPTH + 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 10;
	localparam int GAP_MAX        = 14;
	localparam int HOLD_CYCLES    = 120;

	localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;
	localparam logic signed [COEFF_W-1:0]  C_MAX = 18'sh1FFFF;
	localparam logic signed [COEFF_W-1:0]  C_MIN = 18'sh20000;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] i;
		logic signed [SAMPLE_W-1:0] q;
	} iq_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] i_in;
	logic signed [SAMPLE_W-1:0] q_in;
	logic                       out_valid;
	logic                       out_stall;
	logic signed [SAMPLE_W-1:0] i_out;
	logic signed [SAMPLE_W-1:0] q_out;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [1:0]                 cfg_index;
	logic [COEFF_W-1:0]         cfg_data;

	// shadow of the register file and of the section history
	logic                       run_on    = 1'b0;
	logic                       invert_on = 1'b0;
	logic [COUNT_W-1:0]         stage_sel = 5'd1;
	logic signed [COEFF_W-1:0]  coeff_val = '0;
	logic signed [SAMPLE_W-1:0] sect_x_hist [CASCADE_DEPTH];
	logic signed [SAMPLE_W-1:0] sect_y_hist [CASCADE_DEPTH];

	iq_t rotation_expected [$];
	int  error_count  = 0;
	int  tx_gap_max   = GAP_MAX;
	int  rx_gap_max   = GAP_MAX;
	int  rx_hold      = 0;
	int  quiet_cycles = 0;

	allpass_cascade_phase_rotator #(
		.MAX_STAGES(CASCADE_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.i_in     (i_in),
		.q_in     (q_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.i_out    (i_out),
		.q_out    (q_out),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #HALF_PERIOD clk = ~clk;

	function automatic logic signed [SAMPLE_W-1:0] clip16(input longint v);
		if (v > 32767) return S_MAX;
		if (v < -32768) return S_MIN;
		return v[SAMPLE_W-1:0];
	endfunction

	function automatic void clear_history();
		for (int k = 0; k < CASCADE_DEPTH; k++) begin
			sect_x_hist[k] = '0;
			sect_y_hist[k] = '0;
		end
	endfunction

	function automatic void predict_rotation(input logic signed [SAMPLE_W-1:0] i_s,
			input logic signed [SAMPLE_W-1:0] q_s);
		longint x;
		longint acc;
		int n;
		iq_t res;
		x = longint'(i_s);
		if (invert_on) x = longint'(clip16(-x));
		if (run_on) begin
			if (stage_sel == 0) n = 1;
			else if (stage_sel > CASCADE_DEPTH) n = CASCADE_DEPTH;
			else n = int'(stage_sel);
			for (int k = 0; k < n; k++) begin
				// Q1.17 * Q1.15 plus x_prev at the same weight, round half up to Q1.15
				acc = longint'(coeff_val) * (x - longint'(sect_y_hist[k]))
					+ longint'(sect_x_hist[k]) * 131072 + 65536;
				acc = acc >>> 17;
				sect_x_hist[k] = x[SAMPLE_W-1:0];
				sect_y_hist[k] = clip16(acc);
				x = longint'(sect_y_hist[k]);
			end
		end
		res.i = x[SAMPLE_W-1:0];
		res.q = q_s;
		rotation_expected.push_back(res);
	endfunction

	function automatic void apply_reg(input cfg_reg_t idx, input logic [COEFF_W-1:0] data);
		case (idx)
			REG_RUN_ENABLE: begin
				run_on = data[0];
				clear_history();
			end
			REG_INVERT_I: begin
				invert_on = data[0];
			end
			REG_STAGE_COUNT: begin
				stage_sel = data[COUNT_W-1:0];
				clear_history();
			end
			REG_ALLPASS_COEFF: begin
				coeff_val = data;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return S_MAX;
			1: return S_MIN;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [COEFF_W-1:0] rand_coeff();
		case ($urandom_range(0, 7))
			0: return C_MAX;
			1: return C_MIN;
			default: return COEFF_W'($urandom);
		endcase
	endfunction

	// register value in the low bits, junk above them
	function automatic logic [COEFF_W-1:0] with_junk(input logic [COEFF_W-1:0] v, input int w);
		logic [COEFF_W-1:0] mask;
		mask = (COEFF_W'(1) << w) - COEFF_W'(1);
		return (COEFF_W'($urandom) & ~mask) | (v & mask);
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] i_s,
			input logic signed [SAMPLE_W-1:0] q_s);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		i_in     <= i_s;
		q_in     <= q_s;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_rotation(i_s, q_s);
	endtask

	task automatic send_random(input int count);
		for (int n = 0; n < count; n++) send_sample(rand_sample(), rand_sample());
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [COEFF_W-1:0] data);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (rotation_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic test_bypass();
		send_sample(S_MAX, S_MIN);
		send_sample(S_MIN, S_MAX);
		send_sample(16'sd0, -16'sd1);
		send_sample(-16'sd1, 16'sd0);
		drain_results();
	endtask

	task automatic test_invert();
		write_reg(REG_INVERT_I, 18'd1);
		send_sample(S_MIN, 16'sd5);
		send_sample(S_MAX, S_MIN);
		send_sample(16'sd1, S_MAX);
		drain_results();
		write_reg(REG_INVERT_I, 18'd0);
	endtask

	task automatic test_coeff_extremes();
		write_reg(REG_RUN_ENABLE, 18'd1);
		write_reg(REG_STAGE_COUNT, 18'd1);
		write_reg(REG_ALLPASS_COEFF, C_MAX);
		send_sample(S_MAX, 16'sd0);
		send_sample(S_MIN, 16'sd0);
		send_sample(S_MAX, 16'sd0);
		drain_results();
		write_reg(REG_ALLPASS_COEFF, C_MIN);
		send_sample(S_MIN, S_MAX);
		send_sample(S_MAX, S_MIN);
		send_sample(S_MIN, S_MAX);
		drain_results();
	endtask

	task automatic test_stage_limits();
		// zero acts as one section
		write_reg(REG_STAGE_COUNT, 18'd0);
		write_reg(REG_ALLPASS_COEFF, rand_coeff());
		send_random(2);
		drain_results();
		// above the cascade depth clamps to the full cascade
		write_reg(REG_STAGE_COUNT, 18'd31);
		send_random(3);
		drain_results();
		write_reg(REG_STAGE_COUNT, 18'd16);
		write_reg(REG_INVERT_I, 18'd1);
		send_sample(S_MIN, 16'sd0);
		send_sample(rand_sample(), rand_sample());
		drain_results();
		write_reg(REG_INVERT_I, 18'd0);
	endtask

	task automatic test_history_clear();
		// same value rewritten still wipes the section history
		write_reg(REG_RUN_ENABLE, 18'd1);
		send_random(2);
		drain_results();
	endtask

	task automatic test_random_settings();
		for (int phase = 0; phase < 14; phase++) begin
			if ($urandom_range(0, 9) < 7)
				write_reg(REG_STAGE_COUNT, with_junk(COEFF_W'($urandom_range(0, 31)), COUNT_W));
			if ($urandom_range(0, 9) < 7)
				write_reg(REG_ALLPASS_COEFF, rand_coeff());
			if ($urandom_range(0, 9) < 7)
				write_reg(REG_INVERT_I, with_junk(COEFF_W'($urandom_range(0, 1)), 1));
			if ($urandom_range(0, 9) < 7)
				write_reg(REG_RUN_ENABLE,
					with_junk(COEFF_W'($urandom_range(0, 3) != 0), 1));
			tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
			rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
			send_random(50);
			drain_results();
		end
		tx_gap_max = GAP_MAX;
		rx_gap_max = GAP_MAX;
	endtask

	task automatic test_backpressure();
		write_reg(REG_RUN_ENABLE, 18'd1);
		write_reg(REG_STAGE_COUNT, 18'd16);
		write_reg(REG_ALLPASS_COEFF, rand_coeff());
		tx_gap_max = 0;
		rx_hold    = HOLD_CYCLES;
		send_random(60);
		drain_results();
		tx_gap_max = GAP_MAX;
	endtask

	task automatic test_pause();
		send_random(20);
		drain_results();
		send_random(20);
		drain_results();
	endtask

	// receiver: random stall per result, plus an optional long hold-off
	initial begin
		iq_t want;
		int rx_wait;
		rx_wait   = 0;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (rotation_expected.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("unexpected result: i=%0d q=%0d", i_out, q_out);
				end else begin
					want = rotation_expected.pop_front();
					if (i_out !== want.i) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("i mismatch: expected %0d, got %0d", want.i, i_out);
					end
					if (q_out !== want.q) begin
						error_count++;
						if (error_count <= MAX_REPORTS)
							$display("q mismatch: expected %0d, got %0d", want.q, q_out);
					end
				end
				rx_wait = $urandom_range(0, rx_gap_max);
			end
			@(negedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				out_stall <= 1'b1;
			end else if (rx_wait > 0) begin
				rx_wait--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles without any transfer
	initial begin
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
					|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("FAIL allpass_cascade_phase_rotator");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		i_in      = '0;
		q_in      = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_RUN_ENABLE;
		cfg_data  = '0;
		clear_history();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_bypass();
		test_invert();
		test_coeff_extremes();
		test_stage_limits();
		test_history_clear();
		test_random_settings();
		test_backpressure();
		test_pause();

		if (rotation_expected.size() != 0) begin
			error_count++;
			$display("%0d results never arrived", rotation_expected.size());
		end
		if (error_count == 0) begin
			$display("PASS allpass_cascade_phase_rotator");
		end else begin
			$display("FAIL allpass_cascade_phase_rotator");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+sv
sv/apc_pkg.sv
sv/apc_cell.sv
sv/allpass_cascade_phase_rotator.sv
dv/allpass_cascade_phase_rotator_tb.sv
